>>> design/crrc_pkg.sv
`default_nettype none
package crrc_pkg;

	localparam int COORD_BITS     = 16;
	localparam int ANGLE_BITS     = 12;
	localparam int TRIG_FRAC_BITS = 14;

	localparam int RAD_W  = COORD_BITS - 1;
	localparam int NEAR_W = COORD_BITS + 2;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int TRIG_W = TRIG_FRAC_BITS + 2;
	localparam int PROD_W = DIFF_W + TRIG_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int ROT_W  = SUM_W - TRIG_FRAC_BITS;

	// Quarter-wave polynomial works in unsigned Q30; values reach 2^30.
	localparam int POLY_W = 31;
	localparam logic [POLY_W-1:0] POLY_A = 31'd1686629713;
	localparam logic [POLY_W-1:0] POLY_C = 31'd77846282;
	localparam logic [POLY_W-1:0] POLY_B = 31'd690734171;

endpackage
`default_nettype wire

>>> design/crrc_sincos.sv
`default_nettype none
module crrc_sincos (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic [crrc_pkg::ANGLE_BITS-1:0]    angle,
	output logic signed [crrc_pkg::TRIG_W-1:0]      sine,
	output logic signed [crrc_pkg::TRIG_W-1:0]      cosine
);
	import crrc_pkg::*;

	localparam int QB = ANGLE_BITS - 2;
	localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = {2'b01, {QB{1'b0}}};
	localparam logic [POLY_W-1:0] ROUND_HALF = POLY_W'(1) << (29 - TRIG_FRAC_BITS);

	function automatic logic [POLY_W-1:0] quarter_arg(input logic [ANGLE_BITS-1:0] a);
		logic [QB:0] r;
		r = {1'b0, a[QB-1:0]};
		if (a[QB]) begin
			r = {1'b1, {QB{1'b0}}} - r;
		end
		return {r, {(30 - QB){1'b0}}};
	endfunction

	logic [ANGLE_BITS-1:0] lane_angle [2];
	logic [POLY_W-1:0]     x_s1 [2];
	logic [POLY_W-1:0]     x_s2 [2];
	logic [POLY_W-1:0]     x_s3 [2];
	logic [POLY_W-1:0]     x_s4 [2];
	logic [POLY_W-1:0]     x2_s2 [2];
	logic [POLY_W-1:0]     x2_s3 [2];
	logic [POLY_W-1:0]     t1_s3 [2];
	logic [POLY_W-1:0]     p_s4 [2];
	logic                  neg_s1 [2];
	logic                  neg_s2 [2];
	logic                  neg_s3 [2];
	logic                  neg_s4 [2];
	logic signed [TRIG_W-1:0] trig_s5 [2];

	logic [2*POLY_W-1:0]   sq_prod [2];
	logic [2*POLY_W-1:0]   c_prod [2];
	logic [2*POLY_W-1:0]   b_prod [2];
	logic [2*POLY_W-1:0]   y_prod [2];
	logic [POLY_W-1:0]     b_term [2];
	logic [POLY_W-1:0]     y_round [2];
	logic [TRIG_FRAC_BITS:0] y_mag [2];

	assign lane_angle[0] = angle;
	assign lane_angle[1] = angle + QUARTER_TURN;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			sq_prod[i] = x_s1[i] * x_s1[i];
			c_prod[i]  = x2_s2[i] * POLY_C;
			b_term[i]  = POLY_B - t1_s3[i];
			b_prod[i]  = x2_s3[i] * b_term[i];
			y_prod[i]  = x_s4[i] * p_s4[i];
			y_round[i] = y_prod[i][POLY_W+29:30] + ROUND_HALF;
			y_mag[i]   = y_round[i][30:30-TRIG_FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				x_s1[i]   <= quarter_arg(lane_angle[i]);
				neg_s1[i] <= lane_angle[i][ANGLE_BITS-1];

				x_s2[i]   <= x_s1[i];
				x2_s2[i]  <= sq_prod[i][POLY_W+29:30];
				neg_s2[i] <= neg_s1[i];

				x_s3[i]   <= x_s2[i];
				x2_s3[i]  <= x2_s2[i];
				t1_s3[i]  <= c_prod[i][POLY_W+29:30];
				neg_s3[i] <= neg_s2[i];

				x_s4[i]   <= x_s3[i];
				p_s4[i]   <= POLY_A - b_prod[i][POLY_W+29:30];
				neg_s4[i] <= neg_s3[i];

				trig_s5[i] <= neg_s4[i] ? -$signed({1'b0, y_mag[i]})
				                        : $signed({1'b0, y_mag[i]});
			end
		end
	end

	assign sine   = trig_s5[0];
	assign cosine = trig_s5[1];

endmodule
`default_nettype wire

>>> design/circle_rotated_rect_collision.sv
`default_nettype none
// Circle against rotated rectangle collision test in a fully pipelined datapath.
// One item enters per cycle while the output is not stalled; the pipeline
// depth comes from the quarter-wave sine polynomial (four dependent
// multiplies), the rotation multiplies, the corner min/max, the clamp and
// the squared-distance compare, each in its own register stage. When the
// output item is not taken the whole pipeline holds, and in_ready drops in
// the same cycle. The nearest point is given in world coordinates of the
// rotated frame about the circle center, saturated to the output width.
module circle_rotated_rect_collision (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [crrc_pkg::COORD_BITS-1:0] center_x,
	input  wire logic signed [crrc_pkg::COORD_BITS-1:0] center_y,
	input  wire logic [crrc_pkg::RAD_W-1:0]            radius,
	input  wire logic signed [crrc_pkg::COORD_BITS-1:0] corner_a_x,
	input  wire logic signed [crrc_pkg::COORD_BITS-1:0] corner_a_y,
	input  wire logic signed [crrc_pkg::COORD_BITS-1:0] corner_b_x,
	input  wire logic signed [crrc_pkg::COORD_BITS-1:0] corner_b_y,
	input  wire logic signed [crrc_pkg::COORD_BITS-1:0] corner_c_x,
	input  wire logic signed [crrc_pkg::COORD_BITS-1:0] corner_c_y,
	input  wire logic [crrc_pkg::ANGLE_BITS-1:0]       rect_angle,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       hit,
	output logic signed [crrc_pkg::NEAR_W-1:0]         nearest_x,
	output logic signed [crrc_pkg::NEAR_W-1:0]         nearest_y
);
	import crrc_pkg::*;

	localparam int NUM_STAGES = 11;
	localparam logic signed [SUM_W-1:0] ROT_HALF = SUM_W'(1) << (TRIG_FRAC_BITS - 1);
	localparam logic signed [ROT_W:0] NEAR_MAX =
		{{(ROT_W + 2 - NEAR_W){1'b0}}, {(NEAR_W - 1){1'b1}}};
	localparam logic signed [ROT_W:0] NEAR_MIN = ~NEAR_MAX;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [RAD_W-1:0]             rad;
	} ctx_t;

	logic [NUM_STAGES-1:0] vld_q;
	logic                  adv;

	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8, ctx_s9;

	logic signed [COORD_BITS-1:0] in_cx [3];
	logic signed [COORD_BITS-1:0] in_cy [3];
	logic signed [DIFF_W-1:0] dx_s1 [3], dx_s2 [3], dx_s3 [3], dx_s4 [3], dx_s5 [3];
	logic signed [DIFF_W-1:0] dy_s1 [3], dy_s2 [3], dy_s3 [3], dy_s4 [3], dy_s5 [3];

	logic signed [TRIG_W-1:0] sine, cosine;

	logic signed [PROD_W-1:0] pxc_s6 [3], pys_s6 [3], pyc_s6 [3], pxs_s6 [3];
	logic signed [SUM_W-1:0]  sum_x [3], sum_y [3];
	logic signed [ROT_W-1:0]  rx_s7 [3], ry_s7 [3];

	logic signed [ROT_W-1:0]  min_x, max_x, min_y, max_y;
	logic signed [ROT_W-1:0]  min_x_s8, max_x_s8, min_y_s8, max_y_s8;

	logic signed [ROT_W-1:0]  nx, ny;
	logic [ROT_W-1:0]         ax, ay;
	logic signed [ROT_W-1:0]  nx_s9, ny_s9;
	logic [RAD_W-1:0]         ax_s9, ay_s9;
	logic                     in_range_s9;

	logic signed [ROT_W:0]    wx, wy;
	logic signed [NEAR_W-1:0] sat_x, sat_y;
	logic signed [NEAR_W-1:0] near_x_s10, near_y_s10;
	logic [2*RAD_W-1:0]       ax2_s10, ay2_s10, r2_s10;
	logic                     in_range_s10;
	logic [2*RAD_W:0]         d2;

	assign adv       = !vld_q[NUM_STAGES-1] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NUM_STAGES-2:0], in_valid};
		end
	end

	crrc_sincos u_sincos (
		.clk    (clk),
		.en     (adv),
		.angle  (rect_angle),
		.sine   (sine),
		.cosine (cosine)
	);

	assign in_cx[0] = corner_a_x;
	assign in_cx[1] = corner_b_x;
	assign in_cx[2] = corner_c_x;
	assign in_cy[0] = corner_a_y;
	assign in_cy[1] = corner_b_y;
	assign in_cy[2] = corner_c_y;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_x[k] = SUM_W'(pxc_s6[k]) + SUM_W'(pys_s6[k]) + ROT_HALF;
			sum_y[k] = SUM_W'(pyc_s6[k]) - SUM_W'(pxs_s6[k]) + ROT_HALF;
		end
	end

	always_comb begin
		min_x = rx_s7[0];
		max_x = rx_s7[0];
		min_y = ry_s7[0];
		max_y = ry_s7[0];
		for (int k = 1; k < 3; k++) begin
			if (rx_s7[k] < min_x) min_x = rx_s7[k];
			if (rx_s7[k] > max_x) max_x = rx_s7[k];
			if (ry_s7[k] < min_y) min_y = ry_s7[k];
			if (ry_s7[k] > max_y) max_y = ry_s7[k];
		end
	end

	always_comb begin
		priority if (min_x_s8 > 0) begin
			nx = min_x_s8;
		end else if (max_x_s8 < 0) begin
			nx = max_x_s8;
		end else begin
			nx = '0;
		end
		priority if (min_y_s8 > 0) begin
			ny = min_y_s8;
		end else if (max_y_s8 < 0) begin
			ny = max_y_s8;
		end else begin
			ny = '0;
		end
		ax = nx[ROT_W-1] ? ROT_W'(-nx) : ROT_W'(nx);
		ay = ny[ROT_W-1] ? ROT_W'(-ny) : ROT_W'(ny);
	end

	always_comb begin
		wx = (ROT_W+1)'(nx_s9) + (ROT_W+1)'(ctx_s9.cx);
		wy = (ROT_W+1)'(ny_s9) + (ROT_W+1)'(ctx_s9.cy);
		priority if (wx > NEAR_MAX) begin
			sat_x = NEAR_MAX[NEAR_W-1:0];
		end else if (wx < NEAR_MIN) begin
			sat_x = NEAR_MIN[NEAR_W-1:0];
		end else begin
			sat_x = wx[NEAR_W-1:0];
		end
		priority if (wy > NEAR_MAX) begin
			sat_y = NEAR_MAX[NEAR_W-1:0];
		end else if (wy < NEAR_MIN) begin
			sat_y = NEAR_MIN[NEAR_W-1:0];
		end else begin
			sat_y = wy[NEAR_W-1:0];
		end
	end

	assign d2 = (2*RAD_W+1)'(ax2_s10) + (2*RAD_W+1)'(ay2_s10);

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1.cx  <= center_x;
			ctx_s1.cy  <= center_y;
			ctx_s1.rad <= radius;
			for (int k = 0; k < 3; k++) begin
				dx_s1[k] <= DIFF_W'(in_cx[k]) - DIFF_W'(center_x);
				dy_s1[k] <= DIFF_W'(in_cy[k]) - DIFF_W'(center_y);
			end

			ctx_s2 <= ctx_s1;
			ctx_s3 <= ctx_s2;
			ctx_s4 <= ctx_s3;
			ctx_s5 <= ctx_s4;
			ctx_s6 <= ctx_s5;
			ctx_s7 <= ctx_s6;
			ctx_s8 <= ctx_s7;
			ctx_s9 <= ctx_s8;
			for (int k = 0; k < 3; k++) begin
				dx_s2[k] <= dx_s1[k];
				dy_s2[k] <= dy_s1[k];
				dx_s3[k] <= dx_s2[k];
				dy_s3[k] <= dy_s2[k];
				dx_s4[k] <= dx_s3[k];
				dy_s4[k] <= dy_s3[k];
				dx_s5[k] <= dx_s4[k];
				dy_s5[k] <= dy_s4[k];

				pxc_s6[k] <= dx_s5[k] * cosine;
				pys_s6[k] <= dy_s5[k] * sine;
				pyc_s6[k] <= dy_s5[k] * cosine;
				pxs_s6[k] <= dx_s5[k] * sine;

				rx_s7[k] <= ROT_W'(sum_x[k] >>> TRIG_FRAC_BITS);
				ry_s7[k] <= ROT_W'(sum_y[k] >>> TRIG_FRAC_BITS);
			end

			min_x_s8 <= min_x;
			max_x_s8 <= max_x;
			min_y_s8 <= min_y;
			max_y_s8 <= max_y;

			nx_s9       <= nx;
			ny_s9       <= ny;
			ax_s9       <= ax[RAD_W-1:0];
			ay_s9       <= ay[RAD_W-1:0];
			in_range_s9 <= (ax <= ROT_W'(ctx_s8.rad)) && (ay <= ROT_W'(ctx_s8.rad));

			near_x_s10   <= sat_x;
			near_y_s10   <= sat_y;
			ax2_s10      <= ax_s9 * ax_s9;
			ay2_s10      <= ay_s9 * ay_s9;
			r2_s10       <= ctx_s9.rad * ctx_s9.rad;
			in_range_s10 <= in_range_s9;

			hit       <= in_range_s10 && (d2 <= (2*RAD_W+1)'(r2_s10));
			nearest_x <= near_x_s10;
			nearest_y <= near_y_s10;
		end
	end

endmodule
`default_nettype wire

>>> design/crrc_checker.sv
`default_nettype none
module crrc_protocol_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_ready,
	input wire logic                                  out_valid,
	input wire logic                                  out_ready,
	input wire logic                                  hit,
	input wire logic signed [crrc_pkg::NEAR_W-1:0]    nearest_x,
	input wire logic signed [crrc_pkg::NEAR_W-1:0]    nearest_y
);

	// A result item that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// A stalled result item keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(hit) && $stable(nearest_x) && $stable(nearest_y))
		else $error("result payload changed while stalled");

	// A stalled output freezes the pipeline, so no new item may enter.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item accepted while the pipeline is frozen");

	// With no result waiting the pipeline always moves and is ready to take an item.
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused while the output is free");

endmodule

bind circle_rotated_rect_collision crrc_protocol_checker u_crrc_protocol_checker (.*);
`default_nettype wire

>>> dv/crrc_checker.sv
module crrc_checker
	import crrc_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [RAD_W-1:0]             radius,
	input  logic signed [COORD_BITS-1:0] corner_a_x,
	input  logic signed [COORD_BITS-1:0] corner_a_y,
	input  logic signed [COORD_BITS-1:0] corner_b_x,
	input  logic signed [COORD_BITS-1:0] corner_b_y,
	input  logic signed [COORD_BITS-1:0] corner_c_x,
	input  logic signed [COORD_BITS-1:0] corner_c_y,
	input  logic [ANGLE_BITS-1:0]        rect_angle,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         hit,
	input  logic signed [NEAR_W-1:0]     nearest_x,
	input  logic signed [NEAR_W-1:0]     nearest_y,
	output int                           errors,
	output int                           outstanding
);

	typedef struct {
		logic                     hit;
		logic signed [NEAR_W-1:0] near_x;
		logic signed [NEAR_W-1:0] near_y;
	} contact_t;

	contact_t pending_contacts[$];

	// Quarter-wave polynomial in unsigned Q30, rounded to the trig fraction.
	function automatic longint sine_fixed(input logic [ANGLE_BITS-1:0] ang);
		longint unsigned r, x, x2, t, p, y;
		logic [1:0] quad;
		quad = ang[ANGLE_BITS-1 -: 2];
		r = ang[ANGLE_BITS-3:0];
		if (quad[0])
			r = (64'd1 << (ANGLE_BITS - 2)) - r;
		x = r << (30 - (ANGLE_BITS - 2));
		x2 = (x * x) >> 30;
		t = (x2 * 64'(POLY_C)) >> 30;
		t = (x2 * (64'(POLY_B) - t)) >> 30;
		p = 64'(POLY_A) - t;
		y = (x * p) >> 30;
		y = (y + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
		return quad[1] ? -longint'(y) : longint'(y);
	endfunction

	function automatic contact_t collide(input longint cx, input longint cy, input longint rad,
			input longint ax, input longint ay, input longint bx, input longint by,
			input longint qx, input longint qy, input logic [ANGLE_BITS-1:0] ang);
		longint px[3];
		longint py[3];
		longint sn, cs, dx, dy, rx, ry, half, lim, wx, wy;
		longint lo_x, hi_x, lo_y, hi_y, nx, ny, mx, my;
		logic [ANGLE_BITS-1:0] cos_ang;
		contact_t c;
		px[0] = ax;
		py[0] = ay;
		px[1] = bx;
		py[1] = by;
		px[2] = qx;
		py[2] = qy;
		cos_ang = ang + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
		sn = sine_fixed(ang);
		cs = sine_fixed(cos_ang);
		half = longint'(1) << (TRIG_FRAC_BITS - 1);
		lo_x = 0;
		hi_x = 0;
		lo_y = 0;
		hi_y = 0;
		for (int k = 0; k < 3; k++) begin
			dx = px[k] - cx;
			dy = py[k] - cy;
			rx = (dx * cs + dy * sn + half) >>> TRIG_FRAC_BITS;
			ry = (dy * cs - dx * sn + half) >>> TRIG_FRAC_BITS;
			if (k == 0 || rx < lo_x) lo_x = rx;
			if (k == 0 || rx > hi_x) hi_x = rx;
			if (k == 0 || ry < lo_y) lo_y = ry;
			if (k == 0 || ry > hi_y) hi_y = ry;
		end
		nx = 0;
		ny = 0;
		if (nx < lo_x) nx = lo_x;
		else if (nx > hi_x) nx = hi_x;
		if (ny < lo_y) ny = lo_y;
		else if (ny > hi_y) ny = hi_y;
		mx = nx < 0 ? -nx : nx;
		my = ny < 0 ? -ny : ny;
		c.hit = (mx <= rad && my <= rad && mx * mx + my * my <= rad * rad);
		lim = (longint'(1) << (NEAR_W - 1)) - 1;
		wx = nx + cx;
		wy = ny + cy;
		if (wx > lim) wx = lim;
		else if (wx < -lim - 1) wx = -lim - 1;
		if (wy > lim) wy = lim;
		else if (wy < -lim - 1) wy = -lim - 1;
		c.near_x = NEAR_W'(wx);
		c.near_y = NEAR_W'(wy);
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < 40)
			$display("%0t: mismatch: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		contact_t want;
		if (!arst_n) begin
			pending_contacts.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_contacts.size() == 0) begin
					report_mismatch("result item with no query outstanding");
				end else begin
					want = pending_contacts.pop_front();
					if (hit !== want.hit)
						report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
					if (nearest_x !== want.near_x)
						report_mismatch($sformatf("nearest_x %0d, expected %0d",
							nearest_x, want.near_x));
					if (nearest_y !== want.near_y)
						report_mismatch($sformatf("nearest_y %0d, expected %0d",
							nearest_y, want.near_y));
				end
			end
			if (in_valid && in_ready)
				pending_contacts.push_back(collide(longint'(center_x), longint'(center_y),
					longint'(radius), longint'(corner_a_x), longint'(corner_a_y),
					longint'(corner_b_x), longint'(corner_b_y), longint'(corner_c_x),
					longint'(corner_c_y), rect_angle));
			outstanding = pending_contacts.size();
		end
	end

endmodule

>>> dv/tb_top.sv
module tb_top
	import crrc_pkg::*;
;

	localparam real TURN = 6.283185307179586;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [COORD_BITS-1:0] center_x, center_y;
	logic [RAD_W-1:0] radius;
	logic signed [COORD_BITS-1:0] corner_a_x, corner_a_y;
	logic signed [COORD_BITS-1:0] corner_b_x, corner_b_y;
	logic signed [COORD_BITS-1:0] corner_c_x, corner_c_y;
	logic [ANGLE_BITS-1:0] rect_angle;
	logic out_valid;
	logic out_ready;
	logic hit;
	logic signed [NEAR_W-1:0] nearest_x, nearest_y;
	int errors;
	int outstanding;
	logic steady;

	circle_rotated_rect_collision dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.corner_a_x (corner_a_x),
		.corner_a_y (corner_a_y),
		.corner_b_x (corner_b_x),
		.corner_b_y (corner_b_y),
		.corner_c_x (corner_c_x),
		.corner_c_y (corner_c_y),
		.rect_angle (rect_angle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.nearest_x  (nearest_x),
		.nearest_y  (nearest_y)
	);

	crrc_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.corner_a_x  (corner_a_x),
		.corner_a_y  (corner_a_y),
		.corner_b_x  (corner_b_x),
		.corner_b_y  (corner_b_y),
		.corner_c_x  (corner_c_x),
		.corner_c_y  (corner_c_y),
		.rect_angle  (rect_angle),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.nearest_x   (nearest_x),
		.nearest_y   (nearest_y),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= steady || ($urandom_range(99) >= 37);
		end
	end

	task automatic offer_query(input int cx, input int cy, input int r, input int ax,
			input int ay, input int bx, input int by, input int qx, input int qy,
			input int ang);
		int gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < 37 && gap < 8)
				gap++;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		center_x <= COORD_BITS'(cx);
		center_y <= COORD_BITS'(cy);
		radius <= RAD_W'(r);
		corner_a_x <= COORD_BITS'(ax);
		corner_a_y <= COORD_BITS'(ay);
		corner_b_x <= COORD_BITS'(bx);
		corner_b_y <= COORD_BITS'(by);
		corner_c_x <= COORD_BITS'(qx);
		corner_c_y <= COORD_BITS'(qy);
		rect_angle <= ANGLE_BITS'(ang);
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Corners a, b, c of a rectangle with half sizes hw, hh turned by shape_ang about
	// (rcx, rcy); field_ang is what the item claims as its rotation.
	task automatic offer_rectangle(input int cx, input int cy, input int r, input int rcx,
			input int rcy, input int hw, input int hh, input int shape_ang,
			input int field_ang);
		real th, co, si;
		th = TURN * shape_ang / 4096.0;
		co = $cos(th);
		si = $sin(th);
		offer_query(cx, cy, r,
			rcx + int'(-hw * co + hh * si), rcy + int'(-hw * si - hh * co),
			rcx + int'(hw * co + hh * si), rcy + int'(hw * si - hh * co),
			rcx + int'(hw * co - hh * si), rcy + int'(hw * si + hh * co), field_ang);
	endtask

	initial begin
		int kind, cx, cy, hw, hh, ang, reach, guard;
		arst_n = 1'b0;
		in_valid = 1'b0;
		steady = 1'b0;
		center_x = '0;
		center_y = '0;
		radius = '0;
		corner_a_x = '0;
		corner_a_y = '0;
		corner_b_x = '0;
		corner_b_y = '0;
		corner_c_x = '0;
		corner_c_y = '0;
		rect_angle = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Center inside, on the edge, just touching, just missing, zero radius.
		offer_query(0, 0, 160, -320, -160, 320, -160, 320, 160, 0);
		offer_query(0, 0, 0, -160, -320, 160, -320, 160, 320, 1024);
		offer_query(320, 0, 0, -320, -160, 320, -160, 320, 160, 0);
		offer_query(400, 0, 0, -320, -160, 320, -160, 320, 160, 0);
		offer_query(400, 0, 80, -320, -160, 320, -160, 320, 160, 0);
		offer_query(400, 0, 79, -320, -160, 320, -160, 320, 160, 0);
		offer_query(400, 100, 100, -320, -160, 320, -160, 320, 160, 2048);
		// Degenerate shapes: coincident and collinear corners.
		offer_query(0, 0, 200, 100, 100, 100, 100, 100, 100, 2048);
		offer_query(500, 300, 300, 0, 0, 500, 0, 1000, 0, 4095);
		// Field extremes.
		offer_query(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0);
		offer_query(32767, 32767, 0, -32768, -32768, -32768, -32768, -32768, -32768, 512);
		offer_query(0, 0, 32767, -32768, 32767, 32767, 32767, 32767, -32768, 3072);
		offer_query(-32768, 32767, 32767, 32767, -32768, 32767, 32767, -32768, -32768, 1536);
		offer_query(32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767, 32767, 2560);
		offer_query(0, 0, 32767, 20000, 20000, 20100, 20000, 20100, 20100, 3584);
		// Angles around the quadrant boundaries.
		offer_rectangle(1000, -1000, 500, 1300, -600, 300, 200, 1, 1);
		offer_rectangle(0, 0, 300, 400, 400, 500, 100, 1023, 1023);
		offer_rectangle(0, 0, 300, 400, 400, 500, 100, 1025, 1025);
		offer_rectangle(-2000, 500, 800, -1500, 1200, 700, 300, 2047, 2047);
		offer_rectangle(-2000, 500, 800, -1500, 1200, 700, 300, 3071, 3071);
		offer_rectangle(3000, 3000, 1000, 2000, 4000, 900, 600, 3073, 3073);
		offer_rectangle(3000, 3000, 0, 3000, 3000, 900, 600, 4095, 4095);

		for (int n = 0; n < 600; n++) begin
			steady = (n >= 250 && n < 370);
			kind = $urandom_range(99);
			if (kind < 70) begin
				cx = int'($urandom_range(32000)) - 16000;
				cy = int'($urandom_range(32000)) - 16000;
				hw = ($urandom_range(9) == 0) ? $urandom_range(3000) : $urandom_range(600);
				hh = ($urandom_range(9) == 0) ? $urandom_range(3000) : $urandom_range(600);
				ang = $urandom_range(4095);
				reach = hw + hh + 600;
				offer_rectangle(cx, cy, $urandom_range(($urandom_range(3) == 0) ? 4000 : 600),
					cx + int'($urandom_range(2 * reach)) - reach,
					cy + int'($urandom_range(2 * reach)) - reach, hw, hh, ang, ang);
			end else if (kind < 85) begin
				offer_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom);
			end else if (kind < 92) begin
				cx = int'($urandom_range(20000)) - 10000;
				cy = int'($urandom_range(20000)) - 10000;
				offer_rectangle(cx, cy, $urandom_range(1000),
					cx + int'($urandom_range(2000)) - 1000,
					cy + int'($urandom_range(2000)) - 1000, $urandom_range(800),
					$urandom_range(800), $urandom_range(4095), $urandom_range(4095));
			end else begin
				cx = int'($urandom_range(20000)) - 10000;
				cy = int'($urandom_range(20000)) - 10000;
				hw = cx + int'($urandom_range(4000)) - 2000;
				hh = cy + int'($urandom_range(4000)) - 2000;
				offer_query(cx, cy, ($urandom_range(1) == 0) ? 0 : $urandom_range(1500),
					hw, hh, ($urandom_range(1) == 0) ? hw : cx + int'($urandom_range(4000)) - 2000,
					cy + int'($urandom_range(4000)) - 2000,
					cx + int'($urandom_range(4000)) - 2000, hh, $urandom_range(4095));
			end
		end
		steady = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		guard = 0;
		while (outstanding != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (30) @(negedge clk);
		if (outstanding != 0)
			$display("%0d result items never arrived", outstanding);
		if (errors == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
design/crrc_pkg.sv
design/crrc_sincos.sv
design/circle_rotated_rect_collision.sv
design/crrc_checker.sv
dv/crrc_checker.sv
dv/tb_top.sv
